FILE: design/slcd_pkg.sv
package slcd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAB;
  localparam logic [7:0] SYNC_SECOND = 8'hCD;
  localparam logic [7:0] MIN_LENGTH  = 8'd4;
  localparam logic [7:0] CMD_LOW     = 8'd1;
  localparam logic [7:0] CMD_HIGH    = 8'd4;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

  // Queue between the parser and the output stage
  localparam int QDEPTH  = 4;
  localparam int QADDR_W = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  // One classified event from the parser
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;     // payload byte, or received checksum byte at frame end
    logic [7:0] command;
    logic [7:0] sum;      // running sum at frame end
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

FILE: design/sync_length_checksum_deframer_unit.sv
// Frame parser for a received byte stream with a two-byte sync (AB CD),
// a command byte, a total-length byte, payload bytes and an 8-bit sum.
//
// Input channel: one rx_byte per beat on in_valid / in_stall.
// Output channel: at most one result beat per input beat on out_valid /
// out_stall: payload bytes (kind 0), frame end with checksum_ok and
// command_known (kind 1, last set), or a bad-length drop (kind 2, last set).
// Sync and command bytes, and a length byte in range, give no beat.
//
// Throughput is one byte per cycle while in_stall is low. A four-entry queue
// sits between the parser and the output register: a byte accepted by the
// parser is written into the queue, and its result beat is loaded from
// the queue head into the output register. in_stall rises when that queue is
// full, so a stalled receiver backs up into the queue before the input stalls.
//
// The user must write max_length (cfg_we / cfg_data) only while the block is idle;
// the block does not enforce this. Synchronous reset (rst) returns the parser to
// sync hunting, empties the queue, drops any pending result and sets max_length to 255.
module sync_length_checksum_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [7:0] command,
  output logic       checksum_ok,
  output logic       command_known,
  output logic       last
);
  import slcd_pkg::*;

  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        head;
  queue_status_t q_status;

  slcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  slcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  slcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .command       (command),
    .checksum_ok   (checksum_ok),
    .command_known (command_known),
    .last          (last)
  );

endmodule

FILE: design/slcd_front.sv
module slcd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  input  slcd_pkg::queue_status_t q_status,
  output logic                   push,
  output slcd_pkg::entry_t       push_entry
);
  import slcd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] max_length;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] frame_length, frame_length_next;
  logic       has_result;
  logic       accept;
  logic [7:0] sum_add;
  logic [7:0] count_inc;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && has_result;
  assign sum_add   = running_sum + rx_byte;
  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    byte_count_next    = byte_count;
    frame_command_next = frame_command;
    frame_length_next  = frame_length;
    has_result         = 1'b0;
    push_entry.kind    = KIND_PAYLOAD;
    push_entry.data    = rx_byte;
    push_entry.command = frame_command;
    push_entry.sum     = running_sum;
    unique case (phase)
      PH_HUNT2: begin
        if (rx_byte == SYNC_SECOND) begin
          running_sum_next = sum_add;
          byte_count_next  = 8'd2;
          phase_next       = PH_CMD;
        end else if (rx_byte == SYNC_FIRST) begin
          // stay armed, restart the sum here
          running_sum_next = rx_byte;
          byte_count_next  = 8'd1;
        end else begin
          phase_next = PH_HUNT1;
        end
      end
      PH_CMD: begin
        frame_command_next = rx_byte;
        running_sum_next   = sum_add;
        byte_count_next    = 8'd3;
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        frame_length_next = rx_byte;
        running_sum_next  = sum_add;
        byte_count_next   = 8'd4;
        if (rx_byte < MIN_LENGTH || rx_byte > max_length) begin
          phase_next      = PH_HUNT1;
          has_result      = 1'b1;
          push_entry.kind = KIND_DROP;
        end else if (rx_byte == MIN_LENGTH) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = sum_add;
        byte_count_next  = count_inc;
        if (count_inc >= frame_length) phase_next = PH_CHECK;
        has_result      = 1'b1;
        push_entry.kind = KIND_PAYLOAD;
      end
      PH_CHECK: begin
        phase_next      = PH_HUNT1;
        has_result      = 1'b1;
        push_entry.kind = KIND_END;
      end
      default: begin
        if (rx_byte == SYNC_FIRST) begin
          running_sum_next = rx_byte;
          byte_count_next  = 8'd1;
          phase_next       = PH_HUNT2;
        end else begin
          phase_next = PH_HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      max_length    <= MAX_LENGTH_RESET;
      running_sum   <= '0;
      byte_count    <= '0;
      frame_command <= '0;
      frame_length  <= '0;
    end else begin
      if (cfg_we) max_length <= cfg_data;
      if (accept) begin
        phase         <= phase_next;
        running_sum   <= running_sum_next;
        byte_count    <= byte_count_next;
        frame_command <= frame_command_next;
        frame_length  <= frame_length_next;
      end
    end
  end

endmodule

FILE: design/slcd_queue.sv
module slcd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  slcd_pkg::entry_t        push_entry,
  input  logic                    pop,
  output slcd_pkg::entry_t        head,
  output slcd_pkg::queue_status_t status
);
  import slcd_pkg::*;

  entry_t             slots [QDEPTH];
  logic [QADDR_W-1:0] wr_ptr;
  logic [QADDR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QADDR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QADDR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/slcd_back.sv
module slcd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  slcd_pkg::entry_t        head,
  input  slcd_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              kind,
  output logic [7:0]              data_byte,
  output logic [7:0]              command,
  output logic                    checksum_ok,
  output logic                    command_known,
  output logic                    last
);
  import slcd_pkg::*;

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the beat while stalled, load a new one on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      kind          <= head.kind;
      data_byte     <= (head.kind == KIND_PAYLOAD) ? head.data : 8'd0;
      command       <= head.command;
      checksum_ok   <= (head.kind == KIND_END) && (head.data == head.sum);
      command_known <= (head.command >= CMD_LOW) && (head.command <= CMD_HIGH);
      last          <= (head.kind != KIND_PAYLOAD);
    end
  end

endmodule
